/* hw/rtl/uart_pkg.sv */
// ----------------------------------------------------------------------------
// uart_pkg
// Shared types and constants of the 8N1 transceiver with receive ring
// ----------------------------------------------------------------------------
`default_nettype none

package uart_pkg;

    localparam int RING_DEPTH    = 16;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int TICKS_PER_BIT = 3;
    localparam int FRAME_BITS    = 9;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int TX_TICK_W     = $clog2(TICKS_PER_BIT + 1);
    localparam int RX_TICK_W     = $clog2(TICKS_PER_BIT + 2);
    localparam int BITS_W        = 4;
    localparam int COUNT_W       = 8;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DISABLED = 2'd1;
    localparam logic [1:0] STATUS_BUSY     = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_OFF,
        CMD_TICK,
        CMD_SEND,
        CMD_READ
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       rx_level;
        logic [7:0] tx_byte;
    } t_in_word;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] rx_data;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        t_cmd       cmd;
        logic       rx_level;
        logic [7:0] tx_byte;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* hw/rtl/uart_front.sv */
// ----------------------------------------------------------------------------
// uart_front
// Accepts request words and classifies them into commands for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module uart_front (
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  uart_pkg::t_in_word  i_in_word,
    input  wire                 i_enable,
    input  uart_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output uart_pkg::t_op       o_op
);
    import uart_pkg::*;

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_op.rx_level = i_in_word.rx_level;
        o_op.tx_byte  = i_in_word.tx_byte;
        priority if (i_in_word.req_type != REQ_TICK && i_in_word.req_type != REQ_SEND
                     && i_in_word.req_type != REQ_READ) begin
            o_op.cmd = CMD_NOP;
        end else if (!i_enable) begin
            o_op.cmd = CMD_OFF;
        end else if (i_in_word.req_type == REQ_TICK) begin
            o_op.cmd = CMD_TICK;
        end else if (i_in_word.req_type == REQ_SEND) begin
            o_op.cmd = CMD_SEND;
        end else begin
            o_op.cmd = CMD_READ;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/uart_queue.sv */
// ----------------------------------------------------------------------------
// uart_queue
// Short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module uart_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  uart_pkg::t_op       i_op,
    input  wire                 i_pop,
    output uart_pkg::t_op       o_op,
    output uart_pkg::t_q_stat   o_stat
);
    import uart_pkg::*;

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_op         = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/uart_back.sv */
// ----------------------------------------------------------------------------
// uart_back
// Executes commands: receiver, transmitter, receive ring and result register
// ----------------------------------------------------------------------------
`default_nettype none

module uart_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  uart_pkg::t_op       i_op,
    input  uart_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output uart_pkg::t_out_word o_out_word
);
    import uart_pkg::*;

    logic [7:0]           r_ring [RING_DEPTH];

    logic [7:0]           r_tx_shift,   n_tx_shift;
    logic [7:0]           r_rx_shift,   n_rx_shift;
    logic [TX_TICK_W-1:0] r_tx_tick,    n_tx_tick;
    logic [RX_TICK_W-1:0] r_rx_tick,    n_rx_tick;
    logic [BITS_W-1:0]    r_tx_bits,    n_tx_bits;
    logic [BITS_W-1:0]    r_rx_bits,    n_rx_bits;
    logic                 r_tx_busy,    n_tx_busy;
    logic                 r_rx_busy,    n_rx_busy;
    logic                 r_tx_line,    n_tx_line;
    logic [COUNT_W-1:0]   r_wr_count,   n_wr_count;
    logic [COUNT_W-1:0]   r_rd_count,   n_rd_count;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 w_ring_we;
    logic                 w_rd_ok;
    logic [1:0]           w_status;
    logic [TX_TICK_W-1:0] w_tx_dec;
    logic [RX_TICK_W-1:0] w_rx_dec;
    logic [BITS_W-1:0]    w_tx_bits_dec;
    logic [BITS_W-1:0]    w_rx_bits_dec;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_tx_dec      = r_tx_tick - 1'b1;
    assign w_rx_dec      = r_rx_tick - 1'b1;
    assign w_tx_bits_dec = r_tx_bits - 1'b1;
    assign w_rx_bits_dec = r_rx_bits - 1'b1;

    always_comb begin
        n_tx_shift = r_tx_shift;
        n_rx_shift = r_rx_shift;
        n_tx_tick  = r_tx_tick;
        n_rx_tick  = r_rx_tick;
        n_tx_bits  = r_tx_bits;
        n_rx_bits  = r_rx_bits;
        n_tx_busy  = r_tx_busy;
        n_rx_busy  = r_rx_busy;
        n_tx_line  = r_tx_line;
        n_wr_count = r_wr_count;
        n_rd_count = r_rd_count;
        w_ring_we  = 1'b0;
        w_rd_ok    = 1'b0;
        w_status   = STATUS_OK;
        unique case (i_op.cmd)
            CMD_OFF: begin
                w_status = STATUS_DISABLED;
            end
            CMD_TICK: begin
                // receiver
                if (r_rx_busy) begin
                    n_rx_tick = w_rx_dec;
                    if (w_rx_dec == '0) begin
                        n_rx_tick = RX_TICK_W'(TICKS_PER_BIT);
                        n_rx_bits = w_rx_bits_dec;
                        if (w_rx_bits_dec == '0) begin
                            n_rx_busy  = 1'b0;
                            w_ring_we  = 1'b1;
                            n_wr_count = r_wr_count + 1'b1;
                        end else begin
                            n_rx_shift = {i_op.rx_level, r_rx_shift[7:1]};
                        end
                    end
                end else if (!i_op.rx_level) begin
                    n_rx_busy = 1'b1;
                    n_rx_tick = RX_TICK_W'(TICKS_PER_BIT + 1);
                    n_rx_bits = BITS_W'(FRAME_BITS);
                end
                // transmitter
                if (r_tx_busy) begin
                    n_tx_tick = w_tx_dec;
                    if (w_tx_dec == '0) begin
                        n_tx_tick = TX_TICK_W'(TICKS_PER_BIT);
                        if (r_tx_bits == '0) begin
                            n_tx_line = 1'b0;
                            n_tx_bits = BITS_W'(FRAME_BITS);
                        end else begin
                            n_tx_bits = w_tx_bits_dec;
                            if (w_tx_bits_dec == '0) begin
                                n_tx_line = 1'b1;
                                n_tx_busy = 1'b0;
                            end else begin
                                n_tx_line  = r_tx_shift[0];
                                n_tx_shift = {1'b0, r_tx_shift[7:1]};
                            end
                        end
                    end
                end
            end
            CMD_SEND: begin
                if (r_tx_busy) begin
                    w_status = STATUS_BUSY;
                end else begin
                    n_tx_shift = i_op.tx_byte;
                    n_tx_busy  = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_wr_count == r_rd_count) begin
                    w_status = STATUS_BUSY;
                end else begin
                    w_rd_ok    = 1'b1;
                    n_rd_count = r_rd_count + 1'b1;
                end
            end
            CMD_NOP: begin
                w_status = STATUS_OK;
            end
            default: begin
                w_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_ring_we) begin
            r_ring[r_wr_count[RING_AW-1:0]] <= r_rx_shift;
        end
        if (o_pop) begin
            r_out_word.tx_level <= n_tx_line;
            r_out_word.status   <= w_status;
            r_out_word.rx_data  <= w_rd_ok ? r_ring[r_rd_count[RING_AW-1:0]] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift  <= '0;
            r_rx_shift  <= '0;
            r_tx_tick   <= TX_TICK_W'(TICKS_PER_BIT);
            r_rx_tick   <= '0;
            r_tx_bits   <= '0;
            r_rx_bits   <= '0;
            r_tx_busy   <= 1'b0;
            r_rx_busy   <= 1'b0;
            r_tx_line   <= 1'b1;
            r_wr_count  <= '0;
            r_rd_count  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tx_shift  <= n_tx_shift;
                r_rx_shift  <= n_rx_shift;
                r_tx_tick   <= n_tx_tick;
                r_rx_tick   <= n_rx_tick;
                r_tx_bits   <= n_tx_bits;
                r_rx_bits   <= n_rx_bits;
                r_tx_busy   <= n_tx_busy;
                r_rx_busy   <= n_rx_busy;
                r_tx_line   <= n_tx_line;
                r_wr_count  <= n_wr_count;
                r_rd_count  <= n_rd_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/uart_8n1_transceiver_fifo.sv */
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_fifo
// 8N1 transceiver driven by request words, with a 16-entry receive ring
// ----------------------------------------------------------------------------
// a request word is held in the queue, then its result is registered in the result register
// throughput: one request word per cycle while neither the queue nor the output stalls
// a two-entry queue parts the input side from the result register
// reset (synchronous, active low) clears control state and disables the block
// ring contents are not cleared and hold garbage until written
`default_nettype none

module uart_8n1_transceiver_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  uart_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output uart_pkg::t_out_word o_out_word,
    input  wire                 i_cfg_wen,
    input  wire                 i_cfg_wdata
);
    import uart_pkg::*;

    logic    r_enable;
    logic    w_push;
    logic    w_pop;
    t_op     w_front_op;
    t_op     w_head_op;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wen) begin
            r_enable <= i_cfg_wdata;
        end
    end

    uart_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_enable   (r_enable),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_op       (w_front_op)
    );

    uart_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_stat  (w_q_stat)
    );

    uart_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_head_op),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_stat.empty)
        else $error("queue empty after push");

    a_full_xor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue full and empty at once");

endmodule

`default_nettype wire
